/* rtl/msl_pkg.sv */
// Shared types and constants of the multi-servo slew limiter.
package msl_pkg;

  localparam int SERVO_COUNT = 4;
  localparam int MAX_SPEED   = 255;
  localparam int STEP_FACTOR = 3;

  localparam int CH_IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam int POS_W    = 16;
  localparam int SPEED_W  = 8;
  localparam int STEP_W   = 10;
  localparam int CHAN_W   = 3;
  localparam int NUM_W    = 4;
  localparam int MASK_W   = 4;
  localparam int ENTRY_W  = 2 * POS_W + SPEED_W;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_ENABLE_MASK = 2'd0;
  localparam logic [1:0] REG_INIT_POS    = 2'd1;
  localparam logic [1:0] REG_USE_RAMP    = 2'd2;

  localparam logic [POS_W-1:0] INIT_POS_RESET = 16'd1500;

  typedef enum logic [1:0] {
    CMD_SET_ONE = 2'd0,
    CMD_SET_ALL = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_READ   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  // One channel's stored state, as held in the state memory.
  typedef struct packed {
    logic [POS_W-1:0]   current;
    logic [POS_W-1:0]   target;
    logic [SPEED_W-1:0] speed;
  } entry_t;

  typedef struct packed {
    logic [MASK_W-1:0] enable_mask;
    logic [POS_W-1:0]  init_position;
    logic              use_ramp;
  } cfg_t;

  // Command context handed to the channel update unit.
  typedef struct packed {
    cmd_t                cmd;
    logic [CH_IDX_W-1:0] ch;
    logic [SPEED_W-1:0]  speed;
    logic [POS_W-1:0]    target;
    logic                enabled;
    logic                use_ramp;
  } op_t;

  typedef struct packed {
    kind_t              kind;
    logic [CHAN_W-1:0]  channel;
    logic [POS_W-1:0]   position;
    logic [POS_W-1:0]   target_out;
    logic [SPEED_W-1:0] speed_out;
  } result_t;

endpackage

/* rtl/msl_ram.sv */
// Generic single-port RAM with registered read.
module msl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                            clk,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic                            we,
  input  logic [WIDTH-1:0]                wdata,
  output logic [WIDTH-1:0]                rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/msl_regs.sv */
// APB configuration registers of the slew limiter.
module msl_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [msl_pkg::APB_AW-1:0]   paddr,
  input  logic [msl_pkg::APB_DW-1:0]   pwdata,
  output logic [msl_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output msl_pkg::cfg_t                cfg,
  output logic                         init_load
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite && pready;

  // A write of the start position reloads every channel.
  assign init_load = wr && (idx == msl_pkg::REG_INIT_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_mask   <= '0;
      cfg.init_position <= msl_pkg::INIT_POS_RESET;
      cfg.use_ramp      <= 1'b1;
    end else if (wr) begin
      case (idx)
        msl_pkg::REG_ENABLE_MASK: cfg.enable_mask   <= pwdata[msl_pkg::MASK_W-1:0];
        msl_pkg::REG_INIT_POS:    cfg.init_position <= pwdata[msl_pkg::POS_W-1:0];
        msl_pkg::REG_USE_RAMP:    cfg.use_ramp      <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      msl_pkg::REG_ENABLE_MASK: prdata = msl_pkg::APB_DW'(cfg.enable_mask);
      msl_pkg::REG_INIT_POS:    prdata = msl_pkg::APB_DW'(cfg.init_position);
      msl_pkg::REG_USE_RAMP:    prdata = msl_pkg::APB_DW'(cfg.use_ramp);
      default:                  prdata = '0;
    endcase
  end

endmodule

/* rtl/msl_chan_alu.sv */
// Per-channel read-modify-write: set, ramp step and read reply.
module msl_chan_alu (
  input  msl_pkg::op_t     op,
  input  msl_pkg::entry_t  entry,
  output logic             wr_en,
  output msl_pkg::entry_t  entry_new,
  output logic             has_res,
  output msl_pkg::result_t res
);

  logic [msl_pkg::SPEED_W-1:0] spd_sat;
  logic [msl_pkg::STEP_W-1:0]  step;
  logic [msl_pkg::POS_W-1:0]   step_w;
  logic [msl_pkg::POS_W-1:0]   diff_up;
  logic [msl_pkg::POS_W-1:0]   diff_dn;
  logic [msl_pkg::POS_W-1:0]   ramp_pos;
  logic [msl_pkg::CHAN_W-1:0]  chan_num;

  assign spd_sat = (op.speed > msl_pkg::SPEED_W'(msl_pkg::MAX_SPEED)) ?
                   msl_pkg::SPEED_W'(msl_pkg::MAX_SPEED) : op.speed;
  assign step    = msl_pkg::STEP_W'(entry.speed) * msl_pkg::STEP_W'(msl_pkg::STEP_FACTOR);
  assign step_w  = msl_pkg::POS_W'(step);
  assign diff_up = entry.target - entry.current;
  assign diff_dn = entry.current - entry.target;
  assign chan_num = msl_pkg::CHAN_W'(op.ch) + msl_pkg::CHAN_W'(1);

  // Clamp the step at the target.
  always_comb begin
    if (entry.current < entry.target) begin
      ramp_pos = (diff_up <= step_w) ? entry.target : entry.current + step_w;
    end else begin
      ramp_pos = (diff_dn <= step_w) ? entry.target : entry.current - step_w;
    end
  end

  always_comb begin
    wr_en          = 1'b0;
    entry_new      = entry;
    has_res        = 1'b0;
    res.kind       = msl_pkg::KIND_UPDATE;
    res.channel    = chan_num;
    res.position   = '0;
    res.target_out = '0;
    res.speed_out  = '0;
    case (op.cmd)
      msl_pkg::CMD_SET_ONE, msl_pkg::CMD_SET_ALL: begin
        if (op.enabled) begin
          wr_en            = 1'b1;
          entry_new.speed  = spd_sat;
          entry_new.target = op.target;
          if (!op.use_ramp) begin
            entry_new.current = op.target;
            has_res           = 1'b1;
            res.position      = op.target;
          end
        end
      end
      msl_pkg::CMD_TICK: begin
        if (entry.current != entry.target) begin
          wr_en             = 1'b1;
          entry_new.current = ramp_pos;
          has_res           = 1'b1;
          res.position      = ramp_pos;
        end
      end
      msl_pkg::CMD_READ: begin
        has_res        = 1'b1;
        res.kind       = msl_pkg::KIND_READ;
        res.position   = entry.current;
        res.target_out = entry.target;
        res.speed_out  = entry.speed;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/multi_servo_slew_limiter_top.sv */
// Top level of the multi-servo slew limiter: sequencer, state memory and result stage.
//
//  channel | dir | handshake          | contents
//  s_      | in  | s_tvalid/s_tready  | tuser: command; tdata: number, speed, target
//  m_      | out | m_tvalid/m_tready  | tuser: result kind; tdata: result; tlast: last
//  apb     | in  | psel/penable       | enable_mask @0, init_position @4, use_ramp @8
//
// Each visited channel goes through a memory read step, then an update and write-back step.
// A broadcast or tick visits every channel and a single-channel command one; an illegal
// channel or a tick with ramping off goes from the accept straight to the flush step.
// One command is worked at a time.
// Reset and start-position writes invalidate all entries; an invalid entry reads as the
// start position with full speed, so no clearing pass is needed.
// A result stalls the sequencer only when an earlier result is still waiting to go out.
module multi_servo_slew_limiter_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [31:0]                s_tdata,   // servo_number[3:0], speed[11:4], target_position[27:12]
  input  logic [1:0]                 s_tuser,   // command[1:0]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [47:0]                m_tdata,   // channel[2:0], position[18:3], target_out[34:19], speed_out[42:35]
  output logic [1:0]                 m_tuser,   // result_kind[1:0]
  output logic                       m_tlast,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [msl_pkg::APB_AW-1:0] paddr,
  input  logic [msl_pkg::APB_DW-1:0] pwdata,
  output logic [msl_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RD    = 4'b0010,
    S_UPD   = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state, state_next;

  msl_pkg::cfg_t cfg;
  logic          init_load;

  logic [msl_pkg::CH_IDX_W-1:0] ch;
  logic                         single;
  msl_pkg::cmd_t                cmd;
  logic [msl_pkg::SPEED_W-1:0]  spd;
  logic [msl_pkg::POS_W-1:0]    tgt;
  logic [msl_pkg::SERVO_COUNT-1:0] vld;

  logic                           pend_valid;
  msl_pkg::result_t               pend;

  logic [msl_pkg::ENTRY_W-1:0] ram_rdata;
  logic                        ram_we;
  msl_pkg::entry_t             entry;
  msl_pkg::entry_t             entry_new;
  msl_pkg::op_t                op;
  logic                        alu_we;
  logic                        has_res;
  msl_pkg::result_t            res;
  logic [msl_pkg::MASK_W-1:0]  en_shift;

  logic                        accept;
  msl_pkg::cmd_t               in_cmd;
  logic [msl_pkg::NUM_W-1:0]   in_num;
  logic                        num_bad;
  logic                        out_free;
  logic                        proceed;
  logic                        last_ch;
  logic                        push_upd;
  logic                        push_fl;

  msl_pkg::result_t            out_res;

  msl_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .init_load (init_load)
  );

  msl_ram #(
    .WIDTH (msl_pkg::ENTRY_W),
    .DEPTH (msl_pkg::SERVO_COUNT)
  ) u_state_ram (
    .clk   (clk),
    .addr  (ch),
    .we    (ram_we),
    .wdata (entry_new),
    .rdata (ram_rdata)
  );

  assign in_cmd  = msl_pkg::cmd_t'(s_tuser);
  assign in_num  = s_tdata[3:0];
  assign num_bad = (in_num == '0) ||
                   (in_num > msl_pkg::NUM_W'(msl_pkg::SERVO_COUNT));

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Entries never written since reset or reload read as the start values.
  always_comb begin
    if (vld[ch]) begin
      entry = msl_pkg::entry_t'(ram_rdata);
    end else begin
      entry.current = cfg.init_position;
      entry.target  = cfg.init_position;
      entry.speed   = msl_pkg::SPEED_W'(msl_pkg::MAX_SPEED);
    end
  end

  assign en_shift    = cfg.enable_mask >> ch;
  assign op.cmd      = cmd;
  assign op.ch       = ch;
  assign op.speed    = spd;
  assign op.target   = tgt;
  assign op.enabled  = en_shift[0];
  assign op.use_ramp = cfg.use_ramp;

  msl_chan_alu u_alu (
    .op        (op),
    .entry     (entry),
    .wr_en     (alu_we),
    .entry_new (entry_new),
    .has_res   (has_res),
    .res       (res)
  );

  // Hold in UPD while a new result would have to displace a waiting one.
  assign proceed  = !(has_res && pend_valid && !out_free);
  assign ram_we   = (state == S_UPD) && proceed && alu_we;
  assign last_ch  = single || (ch == msl_pkg::CH_IDX_W'(msl_pkg::SERVO_COUNT - 1));
  assign push_upd = (state == S_UPD) && proceed && has_res && pend_valid;
  assign push_fl  = (state == S_FLUSH) && pend_valid && out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if ((in_cmd == msl_pkg::CMD_SET_ONE || in_cmd == msl_pkg::CMD_READ) && num_bad) begin
            state_next = S_FLUSH;
          end else if (in_cmd == msl_pkg::CMD_TICK && !cfg.use_ramp) begin
            state_next = S_FLUSH;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD:    state_next = S_UPD;
      S_UPD: begin
        if (proceed) begin
          state_next = last_ch ? S_FLUSH : S_RD;
        end
      end
      S_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Command context.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= in_cmd;
      spd <= s_tdata[11:4];
      tgt <= s_tdata[27:12];
      if (in_cmd == msl_pkg::CMD_SET_ONE || in_cmd == msl_pkg::CMD_READ) begin
        single <= 1'b1;
        ch     <= msl_pkg::CH_IDX_W'(in_num - msl_pkg::NUM_W'(1));
      end else begin
        single <= 1'b0;
        ch     <= '0;
      end
    end else if (state == S_UPD && proceed && !last_ch) begin
      ch <= ch + msl_pkg::CH_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || init_load) begin
      vld <= '0;
    end else if (ram_we) begin
      vld[ch] <= 1'b1;
    end
  end

  // Waiting result: goes out once the next one or the end of the command is known.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (accept && (in_cmd == msl_pkg::CMD_SET_ONE || in_cmd == msl_pkg::CMD_READ)
                 && num_bad) begin
      pend_valid <= 1'b1;
    end else if (state == S_UPD && proceed && has_res) begin
      pend_valid <= 1'b1;
    end else if (push_fl) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend.kind       <= msl_pkg::KIND_ERROR;
      pend.channel    <= '0;
      pend.position   <= '0;
      pend.target_out <= '0;
      pend.speed_out  <= '0;
    end else if (state == S_UPD && proceed && has_res) begin
      pend <= res;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push_upd || push_fl) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_upd || push_fl) begin
      out_res <= pend;
      m_tlast <= push_fl;
    end
  end

  assign m_tuser = out_res.kind;
  assign m_tdata = {5'd0, out_res.speed_out, out_res.target_out, out_res.position,
                    out_res.channel};

  a_we_in_upd: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_UPD)
    else $error("state memory written outside update step");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("new command taken while one is in progress");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    push_fl |=> m_tvalid && m_tlast)
    else $error("final result not marked last");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("result left waiting after command end");

endmodule
